// ===== design/wdd_pkg.sv =====
// shared types, constants and controller state for the word dictionary decompressor
package wdd_pkg;

  // default sizes
  localparam int WORD_SLOTS_DEF   = 10;
  localparam int MAX_WORD_LEN_DEF = 16;

  // byte codes
  localparam logic [7:0] CODE_FIRST = 8'd20;
  localparam logic [7:0] CODE_LAST  = 8'd29;
  localparam logic [7:0] LINE_END   = 8'h0A;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_valid;
    logic out_free;
    logic expand_hit;
    logic last_char;
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXPAND
  } state_t;

endpackage

// ===== design/word_dictionary_decompressor.sv =====
// top level of the word dictionary decompressor
//
//   channel   direction  payload                  handshake
//   in        input      in_item  (in_byte, file_start)   in_valid / in_stall
//   out       output     out_item (out_byte, run_last)    out_valid / out_stall
//
// header and pass-through bytes are accepted directly; a code byte for a word of
// len characters is read out through the single read port of the dictionary
// store, which yields one character a cycle while the output is not stalled.
// rst is synchronous: header parsing restarts and all word slots are unloaded.
// in_stall is high while a word is being read out or the output register is
// full and stalled; out_stall holds the output register and pauses the reader.
module word_dictionary_decompressor #(
  parameter int WORD_SLOTS   = wdd_pkg::WORD_SLOTS_DEF,
  parameter int MAX_WORD_LEN = wdd_pkg::MAX_WORD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wdd_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_stall,
  output wdd_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall
);
  import wdd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller
  wdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  wdd_datapath #(
    .WORD_SLOTS   (WORD_SLOTS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== design/wdd_ctrl.sv =====
// controller state machine: input acceptance and word read sequencing
module wdd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  wdd_pkg::status_t status,
  output wdd_pkg::cmd_t    cmd
);
  import wdd_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall && status.expand_hit) begin
          state_next = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (cmd.issue && status.last_char) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall   = status.rd_valid || !status.out_free;
        cmd.accept = in_valid && !in_stall;
      end
      ST_EXPAND: begin
        cmd.issue = !status.rd_valid || status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/wdd_datapath.sv =====
// datapath: header parser, dictionary store, word reader and output register
module wdd_datapath #(
  parameter int WORD_SLOTS   = wdd_pkg::WORD_SLOTS_DEF,
  parameter int MAX_WORD_LEN = wdd_pkg::MAX_WORD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wdd_pkg::in_item_t  in_item,
  output wdd_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall,
  input  wdd_pkg::cmd_t      cmd,
  output wdd_pkg::status_t   status
);
  import wdd_pkg::*;

  localparam int DEPTH  = WORD_SLOTS * MAX_WORD_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int SLOT_W = $clog2(WORD_SLOTS + 1);
  localparam int IDX_W  = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;

  // dictionary store
  logic [7:0] dict_mem [DEPTH];
  logic [LEN_W-1:0] dict_len [WORD_SLOTS];

  // header parser state
  logic              header_phase;
  logic [SLOT_W-1:0] slot_pointer;
  logic [LEN_W-1:0]  char_pointer;

  // word reader state
  logic [ADDR_W-1:0] exp_base;
  logic [LEN_W-1:0]  exp_k;
  logic [LEN_W-1:0]  exp_len;
  logic [7:0]        rd_byte;
  logic              rd_last;
  logic              rd_valid;

  // output register
  out_item_t out_q;
  logic      out_q_valid;

  // effective header state, with a stream start applied first
  logic              hp_eff;
  logic [SLOT_W-1:0] sp_eff;
  logic [LEN_W-1:0]  cp_eff;
  logic [IDX_W-1:0]  sp_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic              hdr_write;

  // code decode
  logic [7:0]        code_off;
  logic              is_code;
  logic              slot_ok;
  logic [IDX_W-1:0]  code_idx;
  logic [LEN_W-1:0]  code_len;
  logic              hit;
  logic              pass;

  logic              out_free;
  logic              rd_take;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W:0]    k_plus;

  assign hp_eff  = in_item.file_start || header_phase;
  assign sp_eff  = in_item.file_start ? '0 : slot_pointer;
  assign cp_eff  = in_item.file_start ? '0 : char_pointer;
  assign sp_idx  = sp_eff[IDX_W-1:0];
  assign wr_addr = ADDR_W'(ADDR_W'(sp_idx) * ADDR_W'(MAX_WORD_LEN) + ADDR_W'(cp_eff));

  assign hdr_write = cmd.accept && hp_eff && (32'(sp_eff) < WORD_SLOTS)
                     && (in_item.in_byte != LINE_END) && (32'(cp_eff) < MAX_WORD_LEN);

  assign code_off = in_item.in_byte - CODE_FIRST;
  assign is_code  = (in_item.in_byte >= CODE_FIRST) && (in_item.in_byte <= CODE_LAST);
  assign slot_ok  = 32'(code_off) < WORD_SLOTS;
  assign code_idx = code_off[IDX_W-1:0];
  assign code_len = slot_ok ? dict_len[code_idx] : '0;
  assign hit      = !hp_eff && is_code && slot_ok && (code_len != '0);
  assign pass     = !hp_eff && !is_code;

  assign out_free = !out_q_valid || !out_stall;
  assign rd_take  = rd_valid && out_free;
  assign rd_addr  = ADDR_W'(exp_base + ADDR_W'(exp_k));
  assign k_plus   = {1'b0, exp_k} + (LEN_W+1)'(1);

  assign status.rd_valid   = rd_valid;
  assign status.out_free   = out_free;
  assign status.expand_hit = hit;
  assign status.last_char  = (k_plus == {1'b0, exp_len});

  assign out_item  = out_q;
  assign out_valid = out_q_valid;

  // dictionary character store, write in header, registered read in expansion
  always_ff @(posedge clk) begin
    if (hdr_write) begin
      dict_mem[wr_addr] <= in_item.in_byte;
    end
    if (cmd.issue) begin
      rd_byte <= dict_mem[rd_addr];
      rd_last <= status.last_char;
    end
  end

  // header parser and word lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      header_phase <= 1'b1;
      slot_pointer <= '0;
      char_pointer <= '0;
      for (int i = 0; i < WORD_SLOTS; i++) begin
        dict_len[i] <= '0;
      end
    end else if (cmd.accept) begin
      if (in_item.file_start) begin
        for (int i = 0; i < WORD_SLOTS; i++) begin
          dict_len[i] <= '0;
        end
      end
      header_phase <= hp_eff;
      slot_pointer <= sp_eff;
      char_pointer <= cp_eff;
      if (hp_eff) begin
        priority if (32'(sp_eff) >= WORD_SLOTS) begin
          header_phase <= 1'b0;
        end else if (in_item.in_byte == LINE_END) begin
          if (cp_eff == '0) begin
            header_phase <= 1'b0;
          end else begin
            slot_pointer <= SLOT_W'(sp_eff + SLOT_W'(1));
            char_pointer <= '0;
            if (32'(sp_eff) + 1 >= WORD_SLOTS) begin
              header_phase <= 1'b0;
            end
          end
        end else if (32'(cp_eff) < MAX_WORD_LEN) begin
          char_pointer     <= LEN_W'(cp_eff + LEN_W'(1));
          dict_len[sp_idx] <= LEN_W'(cp_eff + LEN_W'(1));
        end else begin
          char_pointer <= cp_eff;
        end
      end
    end
  end

  // word reader pointers
  always_ff @(posedge clk) begin
    if (cmd.accept && hit) begin
      exp_base <= ADDR_W'(ADDR_W'(code_idx) * ADDR_W'(MAX_WORD_LEN));
      exp_k    <= '0;
      exp_len  <= code_len;
    end else if (cmd.issue) begin
      exp_k <= k_plus[LEN_W-1:0];
    end
  end

  // read data valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.issue) begin
      rd_valid <= 1'b1;
    end else if (rd_take) begin
      rd_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q_valid <= 1'b0;
    end else if (cmd.accept && pass) begin
      out_q_valid <= 1'b1;
    end else if (rd_take) begin
      out_q_valid <= 1'b1;
    end else if (!out_stall) begin
      out_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && pass) begin
      out_q.out_byte <= in_item.in_byte;
      out_q.run_last <= 1'b1;
    end else if (rd_take) begin
      out_q.out_byte <= rd_byte;
      out_q.run_last <= rd_last;
    end
  end

endmodule

// ===== dv/word_dictionary_decompressor_tb.sv =====
// testbench for the word dictionary decompressor: header load, word expansion and pass-through
`timescale 1ns / 100ps

module word_dictionary_decompressor_tb;
  import wdd_pkg::*;

  // tracks the dictionary as the block should see it and holds the bytes still owed
  class decomp_scoreboard;
    logic [7:0] word_chars [WORD_SLOTS_DEF][MAX_WORD_LEN_DEF];
    int         word_len [WORD_SLOTS_DEF];
    bit         in_header;
    int         slot_ptr;
    int         char_ptr;
    out_item_t  owed_bytes [$];
    int         errors;

    function new();
      errors = 0;
      restart_stream();
    endfunction

    // a new stream unloads every slot and goes back to header parsing
    function void restart_stream();
      foreach (word_len[s]) word_len[s] = 0;
      in_header = 1'b1;
      slot_ptr  = 0;
      char_ptr  = 0;
    endfunction

    // work out the bytes that one accepted input item causes
    function void note_input(in_item_t it);
      out_item_t r;
      int        slot;
      if (it.file_start) restart_stream();
      if (in_header) begin
        if (slot_ptr >= WORD_SLOTS_DEF) begin
          in_header = 1'b0;
        end else if (it.in_byte == LINE_END) begin
          // empty line closes the header, otherwise move to the next slot
          if (char_ptr == 0) begin
            in_header = 1'b0;
          end else begin
            slot_ptr++;
            char_ptr = 0;
            if (slot_ptr >= WORD_SLOTS_DEF) in_header = 1'b0;
          end
        end else if (char_ptr < MAX_WORD_LEN_DEF) begin
          // characters past the word limit are dropped silently
          word_chars[slot_ptr][char_ptr] = it.in_byte;
          char_ptr++;
          word_len[slot_ptr] = char_ptr;
        end
      end else if (it.in_byte >= CODE_FIRST && it.in_byte <= CODE_LAST) begin
        slot = int'(it.in_byte - CODE_FIRST);
        if (slot < WORD_SLOTS_DEF) begin
          for (int k = 0; k < word_len[slot]; k++) begin
            r.out_byte = word_chars[slot][k];
            r.run_last = (k == word_len[slot] - 1);
            owed_bytes.push_back(r);
          end
        end
      end else begin
        r.out_byte = it.in_byte;
        r.run_last = 1'b1;
        owed_bytes.push_back(r);
      end
    endfunction

    // compare one accepted result item with the oldest owed byte
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual out_byte %h run_last %b",
                 $time, got.out_byte, got.run_last);
        return;
      end
      want = owed_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %h actual %h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last mismatch, expected %b actual %b",
                 $time, want.run_last, got.run_last);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 160;
  localparam int SETTLE_TIME  = 40;

  logic      clk;
  logic      rst;
  in_item_t  in_item;
  logic      in_valid;
  logic      in_stall;
  out_item_t out_item;
  logic      out_valid;
  logic      out_stall;

  decomp_scoreboard sb = new();
  int sent_items;
  int send_quiet;
  int recv_quiet;
  int idle_cycles;

  word_dictionary_decompressor u_top (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // random wait, with occasional runs of no waiting
  task automatic draw_wait(inout int quiet_left, output int n);
    if (quiet_left > 0) begin
      quiet_left--;
      n = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 30);
      n = $urandom_range(0, 16);
    end
  endtask

  function automatic in_item_t mk_item(logic [7:0] b, logic fs);
    in_item_t it;
    it.in_byte    = b;
    it.file_start = fs;
    return it;
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == LINE_END);
    return b;
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(in_item_t it);
    int gap;
    draw_wait(send_quiet, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // hold off the sender until every owed byte has come out
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_bytes.size() != 0) @(posedge clk);
  endtask

  // one stream: header of random words, then a body rich in codes
  task automatic send_stream();
    int  words;
    int  len;
    int  body;
    bit  first;
    first = 1'b1;
    words = ($urandom_range(0, 3) == 0) ? 10 : $urandom_range(0, 9);
    for (int w = 0; w < words; w++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        send_item(mk_item(word_char(), first));
        first = 1'b0;
      end
      send_item(mk_item(LINE_END, 1'b0));
    end
    // ten words close the header on their own
    if (words < 10) send_item(mk_item(LINE_END, first));
    body = $urandom_range(4, 14);
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(0, 2) != 0)
        send_item(mk_item(8'($urandom_range(CODE_FIRST, CODE_LAST)), 1'b0));
      else
        send_item(mk_item(8'($urandom_range(0, 255)), 1'b0));
    end
  endtask

  // noise, with a stray stream restart now and then
  task automatic send_noise();
    int n;
    n = $urandom_range(3, 10);
    for (int k = 0; k < n; k++)
      send_item(mk_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0)));
  endtask

  // receiver: stall a random time before taking each item
  initial begin
    int n;
    out_stall  <= 1'b0;
    recv_quiet = 0;
    do @(posedge clk); while (rst);
    forever begin
      draw_wait(recv_quiet, n);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_item    <= '0;
    sent_items = 0;
    send_quiet = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // long first word: extreme bytes kept, the two past the limit dropped
    send_item(mk_item(8'hFF, 1'b1));
    send_item(mk_item(8'h00, 1'b0));
    for (int k = 0; k < 14; k++) send_item(mk_item(8'(8'h63 + k), 1'b0));
    send_item(mk_item(8'h58, 1'b0));
    send_item(mk_item(8'h59, 1'b0));
    send_item(mk_item(LINE_END, 1'b0));
    // empty line ends the header
    send_item(mk_item(LINE_END, 1'b0));
    // full-length expansion, an unloaded slot, then pass-through edges
    send_item(mk_item(CODE_FIRST, 1'b0));
    send_item(mk_item(CODE_LAST, 1'b0));
    send_item(mk_item(LINE_END, 1'b0));
    send_item(mk_item(CODE_FIRST - 8'd1, 1'b0));
    send_item(mk_item(CODE_LAST + 8'd1, 1'b0));
    send_item(mk_item(8'h00, 1'b0));
    send_item(mk_item(8'hFF, 1'b0));
    drain_pause();

    // random streams, mostly well formed
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_stream();
      if ($urandom_range(0, 3) == 0) drain_pause();
    end

    // wait for the last bytes, then a little longer for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    if (sb.owed_bytes.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d result bytes never arrived", $time, sb.owed_bytes.size());
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== word_dictionary_decompressor.f =====
design/wdd_pkg.sv
design/wdd_ctrl.sv
design/wdd_datapath.sv
design/word_dictionary_decompressor.sv
dv/word_dictionary_decompressor_tb.sv
